/* hdl/assert_macros.svh */
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the outlier filter blocks.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, quiet during reset.
`define WCOF_CHK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, quiet during reset.
`define WCOF_CHK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/wcof_pkg.sv */
// -----------------------------------------------------------------------------
// wcof_pkg
// Types, codes and helpers for the outlier filter top level, controller and datapath.
// -----------------------------------------------------------------------------
`default_nettype none

package wcof_pkg;

  // Width of the series counters and of the controller step counter.
  localparam int CNT_W  = 5;
  localparam int STEP_W = 6;

  // Configuration register indexes.
  localparam logic [2:0] REG_BEGIN   = 3'd0;
  localparam logic [2:0] REG_END     = 3'd1;
  localparam logic [2:0] REG_WIDTH   = 3'd2;
  localparam logic [2:0] REG_K       = 3'd3;
  localparam logic [2:0] REG_THRESH  = 3'd4;
  localparam logic [2:0] REG_REPLACE = 3'd5;

  // Read index selection for the window read port.
  localparam logic [1:0] IDX_ZERO = 2'd0;
  localparam logic [1:0] IDX_SIDE = 2'd1;
  localparam logic [1:0] IDX_PEND = 2'd2;

  typedef struct packed {
    logic              shift_in;
    logic              sidx_inc;
    logic              pend_inc;
    logic              pend_dec;
    logic              drop;
    logic              idx_ld;
    logic [1:0]        idx_sel;
    logic              load;
    logic              sort;
    logic              scan;
    logic              cmp1;
    logic              cmp2;
    logic              div_start;
    logic              div_step;
    logic              out_load;
    logic              out_mean;
    logic              out_last;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic             sidx_lt_s;
    logic             pend_eq_s;
    logic             pend_zero;
    logic             pend_one;
    logic             in_gate;
    logic             hit;
    logic             is_out;
    logic             out_free;
    logic [CNT_W-1:0] cnt_m1;
  } sts_t;

  // floor(w/3) for w up to 31, as a multiply by 11/32.
  function automatic logic [3:0] third(input logic [4:0] w);
    logic [8:0] p;
    p = 9'(w) * 9'd11;
    return p[8:5];
  endfunction

endpackage

`default_nettype wire

/* hdl/wcof_dp.sv */
// -----------------------------------------------------------------------------
// wcof_dp
// Datapath: sample window, sorter, scan accumulators, threshold test, divider
// and output register.
// -----------------------------------------------------------------------------
`default_nettype none

module wcof_dp #(
  parameter int MAX_WINDOW = 31,
  parameter int VB         = 24
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire wcof_pkg::cmd_t          cmd,
  output wcof_pkg::sts_t               sts,
  input  wire logic [31:0]             in_time,
  input  wire logic signed [VB-1:0]    in_value,
  input  wire logic [31:0]             begin_time,
  input  wire logic [31:0]             end_time,
  input  wire logic [4:0]              window_width,
  input  wire logic [3:0]              outlier_count,
  input  wire logic [15:0]             threshold,
  input  wire logic                    cfg_drop,
  input  wire logic                    out_ready,
  output logic                         out_valid,
  output logic [31:0]                  out_time,
  output logic signed [VB-1:0]         out_value,
  output logic                         out_rep,
  output logic                         out_last
);

  localparam int IW = $clog2(MAX_WINDOW);
  localparam int SW = VB + 6;
  localparam int DW = VB + 2;
  localparam int RW = VB + 1;
  localparam int PW = VB + 17;

  logic [31:0]          twin_r [MAX_WINDOW];
  logic signed [VB-1:0] vwin_r [MAX_WINDOW];
  logic signed [VB-1:0] srt_r  [MAX_WINDOW];
  logic signed [VB-1:0] srt_nxt[MAX_WINDOW];

  logic [4:0]    sidx_r, pend_r;
  logic [IW-1:0] rd_idx_r;
  logic [31:0]   tv_r;
  logic signed [VB-1:0] vv_r;
  logic hit_lo_r, hit_hi_r;
  logic signed [SW-1:0] sum_all_r, sum_lo_r, sum_hi_r, msum_r;
  logic signed [VB-1:0] mn_a_r, mx_a_r, mn_b_r, mx_b_r;
  logic [DW-1:0] a_r;
  logic [RW-1:0] r_r;
  logic [PW-1:0] big_r, prod_r;
  logic [SW-1:0] quo_r;
  logic [5:0]    rem_r;
  logic          neg_r;
  logic          out_valid_r;

  logic [3:0] side;
  logic [4:0] cnt, cnt_k, k5, idx5;
  logic [31:0] rd_time;
  logic signed [VB-1:0] rd_value, x, mn, mx;
  logic signed [SW-1:0] xe;
  logic lowz, highz;
  logic signed [DW-1:0] d;
  logic [6:0] remw;
  logic [SW-1:0] mag;

  assign side  = 4'((window_width - 5'd1) >> 1);
  assign cnt   = {side, 1'b1};
  assign k5    = {1'b0, outlier_count};
  assign cnt_k = cnt - k5;
  assign idx5  = cmd.step[4:0];

  assign rd_time  = twin_r[rd_idx_r];
  assign rd_value = vwin_r[rd_idx_r];

  // Window shift line, newest at entry 0.
  always_ff @(posedge clk) begin
    if (cmd.shift_in) begin
      for (int i = MAX_WINDOW - 1; i > 0; i--) begin
        twin_r[i] <= twin_r[i-1];
        vwin_r[i] <= vwin_r[i-1];
      end
      twin_r[0] <= in_time;
      vwin_r[0] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sidx_r <= '0;
      pend_r <= '0;
    end else if (cfg_drop || cmd.drop) begin
      sidx_r <= '0;
      pend_r <= '0;
    end else begin
      if (cmd.sidx_inc) sidx_r <= sidx_r + 5'd1;
      if (cmd.pend_inc) pend_r <= pend_r + 5'd1;
      else if (cmd.pend_dec) pend_r <= pend_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_ld) begin
      case (cmd.idx_sel)
        wcof_pkg::IDX_SIDE: rd_idx_r <= IW'(side);
        wcof_pkg::IDX_PEND: rd_idx_r <= IW'(pend_r - 5'd1);
        default:            rd_idx_r <= '0;
      endcase
    end
  end

  // Odd-even transposition sort over the first cnt entries, then a shift
  // towards entry 0 for the scan.
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) srt_nxt[i] = srt_r[i];
    if (cmd.load) begin
      for (int i = 0; i < MAX_WINDOW; i++) srt_nxt[i] = vwin_r[i];
    end else if (cmd.sort) begin
      for (int j = 0; j < MAX_WINDOW - 1; j++) begin
        if (((j & 1) == int'(cmd.step[0])) && (6'(j + 1) < {1'b0, cnt}) &&
            (srt_r[j] > srt_r[j+1])) begin
          srt_nxt[j]   = srt_r[j+1];
          srt_nxt[j+1] = srt_r[j];
        end
      end
    end else if (cmd.scan) begin
      for (int i = 0; i < MAX_WINDOW - 1; i++) srt_nxt[i] = srt_r[i+1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_WINDOW; i++) srt_r[i] <= srt_nxt[i];
  end

  assign x     = srt_r[0];
  assign xe    = {{(SW-VB){x[VB-1]}}, x};
  assign lowz  = idx5 < k5;
  assign highz = idx5 >= cnt_k;

  assign mn = hit_lo_r ? mn_a_r : mn_b_r;
  assign mx = hit_lo_r ? mx_a_r : mx_b_r;
  assign d  = {vv_r[VB-1], vv_r, 1'b0} - {{2{mx[VB-1]}}, mx} - {{2{mn[VB-1]}}, mn};

  assign mag  = msum_r[SW-1] ? SW'(-msum_r) : SW'(msum_r);
  assign remw = {rem_r, quo_r[SW-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tv_r      <= rd_time;
      vv_r      <= rd_value;
      hit_lo_r  <= 1'b0;
      hit_hi_r  <= 1'b0;
      sum_all_r <= '0;
      sum_lo_r  <= '0;
      sum_hi_r  <= '0;
    end
    if (cmd.scan) begin
      if (lowz && x == vv_r)  hit_lo_r <= 1'b1;
      if (highz && x == vv_r) hit_hi_r <= 1'b1;
      sum_all_r <= sum_all_r + xe;
      if (lowz)  sum_lo_r <= sum_lo_r + xe;
      if (highz) sum_hi_r <= sum_hi_r + xe;
      if (idx5 == k5)          mn_a_r <= x;
      if (idx5 == cnt - 5'd1)  mx_a_r <= x;
      if (idx5 == 5'd0)        mn_b_r <= x;
      if (idx5 == cnt_k - 5'd1) mx_b_r <= x;
    end
    if (cmd.cmp1) begin
      a_r    <= d[DW-1] ? DW'(-d) : DW'(d);
      r_r    <= {mx[VB-1], mx} - {mn[VB-1], mn};
      msum_r <= sum_all_r - (hit_lo_r ? sum_lo_r : sum_hi_r);
    end
    if (cmd.cmp2) begin
      big_r  <= PW'({a_r, 8'b0});
      prod_r <= PW'(r_r) * PW'(threshold);
    end
    if (cmd.div_start) begin
      quo_r <= mag + SW'(cnt_k >> 1);
      rem_r <= '0;
      neg_r <= msum_r[SW-1];
    end else if (cmd.div_step) begin
      if (remw >= {2'b0, cnt_k}) begin
        rem_r <= 6'(remw - {2'b0, cnt_k});
        quo_r <= {quo_r[SW-2:0], 1'b1};
      end else begin
        rem_r <= remw[5:0];
        quo_r <= {quo_r[SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_time  <= cmd.out_mean ? tv_r : rd_time;
      out_value <= cmd.out_mean ? (neg_r ? VB'(-quo_r) : VB'(quo_r)) : rd_value;
      out_rep   <= cmd.out_mean;
      out_last  <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts.sidx_lt_s = sidx_r < {1'b0, side};
    sts.pend_eq_s = pend_r == {1'b0, side};
    sts.pend_zero = pend_r == 5'd0;
    sts.pend_one  = pend_r == 5'd1;
    sts.in_gate   = !(rd_time < begin_time || rd_time > end_time);
    sts.hit       = hit_lo_r || hit_hi_r;
    sts.is_out    = big_r > prod_r;
    sts.out_free  = !out_valid_r || out_ready;
    sts.cnt_m1    = {side, 1'b0};
  end

endmodule

`default_nettype wire

/* hdl/wcof_ctrl.sv */
// -----------------------------------------------------------------------------
// wcof_ctrl
// Controller state machine sequencing one input transaction at a time.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module wcof_ctrl #(
  parameter int DIV_STEPS = 30
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic           in_tlast,
  input  wire logic           replace_mode,
  input  wire wcof_pkg::sts_t sts,
  output wcof_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_SORT  = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_CMP1  = 4'd5;
  localparam logic [3:0] S_CMP2  = 4'd6;
  localparam logic [3:0] S_DEC   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_FLUSH = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [wcof_pkg::STEP_W-1:0] cyc_r, cyc_nxt;
  logic flush_r, flush_nxt, elast_r, elast_nxt, emean_r, emean_nxt;
  logic sweep_end;

  assign sweep_end = cyc_r == {1'b0, sts.cnt_m1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cyc_r   <= '0;
      flush_r <= 1'b0;
      elast_r <= 1'b0;
      emean_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cyc_r   <= cyc_nxt;
      flush_r <= flush_nxt;
      elast_r <= elast_nxt;
      emean_r <= emean_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.step  = cyc_r;
    in_tready = 1'b0;
    state_nxt = state_r;
    cyc_nxt   = cyc_r;
    flush_nxt = flush_r;
    elast_nxt = elast_r;
    emean_nxt = emean_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.shift_in = 1'b1;
          flush_nxt    = in_tlast;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.sidx_lt_s) begin
          cmd.sidx_inc = 1'b1;
          cmd.idx_ld   = 1'b1;
          cmd.idx_sel  = wcof_pkg::IDX_ZERO;
          elast_nxt    = flush_r;
          emean_nxt    = 1'b0;
          state_nxt    = S_EMIT;
        end else if (!sts.pend_eq_s) begin
          cmd.pend_inc = 1'b1;
          state_nxt    = flush_r ? S_FLUSH : S_IDLE;
        end else begin
          cmd.idx_ld  = 1'b1;
          cmd.idx_sel = wcof_pkg::IDX_SIDE;
          state_nxt   = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        cyc_nxt   = '0;
        elast_nxt = 1'b0;
        emean_nxt = 1'b0;
        state_nxt = sts.in_gate ? S_SORT : S_EMIT;
      end
      S_SORT: begin
        cmd.sort = 1'b1;
        if (sweep_end) begin
          cyc_nxt   = '0;
          state_nxt = S_SCAN;
        end else begin
          cyc_nxt = cyc_r + wcof_pkg::STEP_W'(1);
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sweep_end) begin
          cyc_nxt   = '0;
          state_nxt = S_CMP1;
        end else begin
          cyc_nxt = cyc_r + wcof_pkg::STEP_W'(1);
        end
      end
      S_CMP1: begin
        cmd.cmp1  = 1'b1;
        state_nxt = sts.hit ? S_CMP2 : S_EMIT;
      end
      S_CMP2: begin
        cmd.cmp2  = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (!sts.is_out) begin
          state_nxt = S_EMIT;
        end else if (!replace_mode) begin
          state_nxt = flush_r ? S_FLUSH : S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          cyc_nxt       = '0;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cyc_r == wcof_pkg::STEP_W'(DIV_STEPS - 1)) begin
          emean_nxt = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          cyc_nxt = cyc_r + wcof_pkg::STEP_W'(1);
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_mean = emean_r;
          cmd.out_last = elast_r;
          state_nxt    = flush_r ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (sts.pend_zero) begin
          cmd.drop  = 1'b1;
          flush_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          cmd.pend_dec = 1'b1;
          cmd.idx_ld   = 1'b1;
          cmd.idx_sel  = wcof_pkg::IDX_PEND;
          elast_nxt    = sts.pend_one;
          emean_nxt    = 1'b0;
          state_nxt    = S_EMIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `WCOF_CHK_IMP(a_load_free, cmd.out_load, sts.out_free, "result loaded over a full register")
  `WCOF_CHK_NXT(a_acc_disp, in_tvalid && in_tready, state_r == S_DISP, "accept not dispatched")
  `WCOF_CHK_IMP(a_pend_dec, cmd.pend_dec, !sts.pend_zero, "pending count underflow")

endmodule

`default_nettype wire

/* hdl/window_cluster_outlier_filter.sv */
// -----------------------------------------------------------------------------
// window_cluster_outlier_filter
// Sliding-window trimmed-range outlier filter over (time, value) samples.
// -----------------------------------------------------------------------------
// The block takes one input transaction at a time and holds in_tready low
// until every result it causes has been handed to the output register. A
// sample at the start of a series is passed on untested, a sample that is
// only held back produces no result, and a sample outside the time gate is
// passed on without the test. A tested sample with a centred window of
// N = 2*floor((w-1)/2)+1 values goes through the odd-even sort, the rank scan
// over the window and the threshold test, and through the bit-serial divider
// when an outlier is replaced by the mean. A last marker emits each held-back
// sample it flushes and then restarts the series. A result that waits for the
// output register to empty holds the sequence until the register is free.
// The output register lets the next transaction be accepted while a result
// still waits downstream. Configuration writes are taken in any cycle, but are
// only meaningful while the block is idle; changing the window width discards
// the series in progress.
// -----------------------------------------------------------------------------
`default_nettype none

module window_cluster_outlier_filter #(
  parameter int MAX_WINDOW = 31,
  parameter int VALUE_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // tdata: sample_time [31:0], sample_value [VALUE_BITS+31:32], zero pad above
  input  wire logic [((32+VALUE_BITS+7)/8)*8-1:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic        in_tlast,
  // tdata: out_time [31:0], out_value [VALUE_BITS+31:32], zero pad above
  output logic [((32+VALUE_BITS+7)/8)*8-1:0] out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic             out_tlast,
  // tuser: was_replaced [0]
  output logic             out_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int DATA_W = ((32 + VALUE_BITS + 7) / 8) * 8;

  // Configuration registers, already clamped to their legal ranges.
  logic [31:0] begin_r, begin_nxt, end_r, end_nxt;
  logic [4:0]  width_r, width_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [15:0] thr_r, thr_nxt;
  logic        rep_r, rep_nxt;
  logic        cfg_drop;
  logic [4:0]  w_in;
  logic [3:0]  k_in, k_cap;

  wcof_pkg::cmd_t cmd;
  wcof_pkg::sts_t sts;

  logic [31:0]                  res_time;
  logic signed [VALUE_BITS-1:0] res_value;

  // The write port never stalls: every write is registered directly.
  assign cfg_ready = 1'b1;

  always_comb begin
    begin_nxt = begin_r;
    end_nxt   = end_r;
    width_nxt = width_r;
    k_nxt     = k_r;
    thr_nxt   = thr_r;
    rep_nxt   = rep_r;
    cfg_drop  = 1'b0;
    w_in      = cfg_data[4:0];
    if (w_in < 5'd3) begin
      w_in = 5'd3;
    end else if (int'(w_in) > MAX_WINDOW) begin
      w_in = 5'(MAX_WINDOW);
    end
    k_cap = wcof_pkg::third(width_r);
    k_in  = cfg_data[3:0];
    if (k_in == 4'd0) k_in = 4'd1;
    if (k_in > k_cap) k_in = k_cap;
    if (cfg_valid) begin
      unique case (cfg_index)
        wcof_pkg::REG_BEGIN:   begin_nxt = cfg_data;
        wcof_pkg::REG_END:     end_nxt   = cfg_data;
        wcof_pkg::REG_WIDTH: begin
          // A new width restarts the series and may pull k down with it.
          if (w_in != width_r) begin
            width_nxt = w_in;
            cfg_drop  = 1'b1;
            if (k_r > wcof_pkg::third(w_in)) k_nxt = wcof_pkg::third(w_in);
          end
        end
        wcof_pkg::REG_K:       k_nxt   = k_in;
        wcof_pkg::REG_THRESH:  thr_nxt = (cfg_data[15:0] < 16'd768) ? 16'd768 : cfg_data[15:0];
        wcof_pkg::REG_REPLACE: rep_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      begin_r <= 32'd0;
      end_r   <= 32'hFFFF_FFFF;
      width_r <= 5'd5;
      k_r     <= 4'd1;
      thr_r   <= 16'd2560;
      rep_r   <= 1'b0;
    end else begin
      begin_r <= begin_nxt;
      end_r   <= end_nxt;
      width_r <= width_nxt;
      k_r     <= k_nxt;
      thr_r   <= thr_nxt;
      rep_r   <= rep_nxt;
    end
  end

  // The controller sequences sort, scan, test and divide for one sample.
  wcof_ctrl #(
    .DIV_STEPS (VALUE_BITS + 6)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tlast     (in_tlast),
    .replace_mode (rep_r),
    .sts          (sts),
    .cmd          (cmd)
  );

  wcof_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .VB         (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_time       (in_tdata[31:0]),
    .in_value      (in_tdata[32+VALUE_BITS-1:32]),
    .begin_time    (begin_r),
    .end_time      (end_r),
    .window_width  (width_r),
    .outlier_count (k_r),
    .threshold     (thr_r),
    .cfg_drop      (cfg_drop),
    .out_ready     (out_tready),
    .out_valid     (out_tvalid),
    .out_time      (res_time),
    .out_value     (res_value),
    .out_rep       (out_tuser),
    .out_last      (out_tlast)
  );

  assign out_tdata = DATA_W'({res_value, res_time});

endmodule

`default_nettype wire

/* verif/outlier_checker.sv */
// -----------------------------------------------------------------------------
// outlier_checker
// Watches the sample, result and register channels of the outlier filter,
// forms the expected results from its own copy of the filter state and
// compares every result transaction, field by field, against them.
// -----------------------------------------------------------------------------
module outlier_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [55:0] in_tdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic        in_tlast,
  input  logic [55:0] out_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic        out_tlast,
  input  logic        out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 31;

  typedef struct packed {
    logic [31:0]        t;
    logic signed [23:0] v;
    logic               rep;
    logic               last;
  } result_t;

  result_t             expected_q[$];
  logic signed [23:0]  vals[DEPTH];
  logic [31:0]         times[DEPTH];
  int                  seen;
  int                  held;
  logic [31:0]         gate_lo;
  logic [31:0]         gate_hi;
  int                  width;
  int                  k;
  int                  thr;
  logic                replace;

  assign pending_results = expected_q.size();

  function automatic void push_result(logic [31:0] t, logic signed [23:0] v, logic r);
    result_t e;
    e.t = t; e.v = v; e.rep = r; e.last = 1'b0;
    expected_q = {expected_q, e};
  endfunction

  // Tests the centre sample of the window at entry s.
  function automatic void test_centre(int s);
    longint sorted[DEPTH];
    longint x, v, mn, mx, d, sum, c, mag, q;
    int n, lo, hi, j;
    bit hit;
    n = 2 * s + 1;
    v = vals[s];
    hit = 0;
    if (times[s] < gate_lo || times[s] > gate_hi) begin
      push_result(times[s], vals[s], 1'b0);
      return;
    end
    for (int i = 0; i < n; i++) begin
      x = vals[i];
      j = i;
      while (j > 0 && sorted[j-1] > x) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = x;
    end
    for (int i = 0; i < k; i++) if (sorted[i] == v) hit = 1;
    if (hit) begin
      lo = k; hi = n - 1;
    end else begin
      for (int i = n - k; i < n; i++) if (sorted[i] == v) hit = 1;
      if (!hit) begin
        push_result(times[s], vals[s], 1'b0);
        return;
      end
      lo = 0; hi = n - k - 1;
    end
    mn = sorted[lo];
    mx = sorted[hi];
    d = 2 * v - (mx + mn);
    if (d < 0) d = -d;
    // Inlier unless |dev|*256 exceeds thr*range strictly.
    if (d * 256 <= longint'(thr) * (mx - mn)) begin
      push_result(times[s], vals[s], 1'b0);
      return;
    end
    if (!replace) return;
    sum = 0;
    for (int i = lo; i <= hi; i++) sum += sorted[i];
    c = hi - lo + 1;
    mag = sum < 0 ? -sum : sum;
    q = (mag + c / 2) / c;
    push_result(times[s], 24'(sum < 0 ? -q : q), 1'b1);
  endfunction

  function automatic void take_sample(logic [31:0] t, logic signed [23:0] v, logic last);
    int s, n0;
    s = (width - 1) / 2;
    n0 = expected_q.size();
    for (int i = DEPTH - 1; i > 0; i--) begin
      vals[i] = vals[i-1];
      times[i] = times[i-1];
    end
    vals[0] = v;
    times[0] = t;
    if (seen < s) begin
      push_result(t, v, 1'b0);
      seen++;
    end else begin
      held++;
      if (held > s) begin
        test_centre(s);
        held = s;
      end
    end
    if (last) begin
      while (held > 0) begin
        held--;
        push_result(times[held], vals[held], 1'b0);
      end
      if (expected_q.size() > n0) expected_q[expected_q.size()-1].last = 1'b1;
      seen = 0;
      held = 0;
    end
  endfunction

  function automatic void write_register(logic [2:0] idx, logic [31:0] data);
    int w;
    case (idx)
      wcof_pkg::REG_BEGIN: gate_lo = data;
      wcof_pkg::REG_END:   gate_hi = data;
      wcof_pkg::REG_WIDTH: begin
        w = data[4:0];
        if (w < 3) w = 3;
        if (w != width) begin
          width = w;
          if (k > w / 3) k = w / 3;
          seen = 0;
          held = 0;
        end
      end
      wcof_pkg::REG_K: begin
        w = data[3:0];
        if (w < 1) w = 1;
        if (w > width / 3) w = width / 3;
        k = w;
      end
      wcof_pkg::REG_THRESH:  thr = data[15:0] < 768 ? 768 : data[15:0];
      wcof_pkg::REG_REPLACE: replace = data[0];
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t exp_r;
    if (!rst_n) begin
      expected_q.delete();
      seen <= 0;
      held <= 0;
      gate_lo <= '0;
      gate_hi <= '1;
      width <= 5;
      k <= 1;
      thr <= 2560;
      replace <= 1'b0;
      fail_count <= 0;
    end else begin
      // The result is checked before the sample of the same edge is taken in.
      if (out_tvalid && out_tready) begin
        got.t = out_tdata[31:0];
        got.v = out_tdata[55:32];
        got.rep = out_tuser;
        got.last = out_tlast;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: result mismatch, expected t=%h v=%h rep=%b last=%b,",
                     $realtime, exp_r.t, exp_r.v, exp_r.rep, exp_r.last,
                     " actual t=%h v=%h rep=%b last=%b",
                     got.t, got.v, got.rep, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_tvalid && in_tready) take_sample(in_tdata[31:0], in_tdata[55:32], in_tlast);
    end
  end
endmodule

/* verif/tb.sv */
// -----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the sliding-window outlier filter.
// -----------------------------------------------------------------------------
// Sample series are sent in several register settings, with random idling on
// both sides of the stream. A separate checker predicts every result
// transaction and counts mismatches; this module only drives and decides.
// -----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;
  // An index with no register behind it; writes to it must be ignored.
  localparam logic [2:0] REG_UNUSED = 3'd6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [55:0] in_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic        in_tlast = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending_results;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          quiet_cycles = 0;
  logic [31:0] clock_ticks = 0;

  always #1 clk = ~clk;

  window_cluster_outlier_filter u_top (.*);

  outlier_checker u_chk (.*);

  // The receiver stalls at random with the current idling percentage.
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  // The watchdog restarts whenever any transaction is accepted.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("[window_cluster_outlier_filter] ERROR");
      $finish;
    end
  end

  // Writes back to back keep cfg_valid high; the caller lowers it afterwards.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Sends one sample transaction; time stamps rise so the gate is meaningful.
  task automatic send_sample(logic signed [23:0] v, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    clock_ticks = clock_ticks + $urandom_range(1, 40);
    in_tvalid <= 1'b1;
    in_tdata <= {v, clock_ticks};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // Lets the block finish: every expected result delivered, then its latency.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // Mostly a smooth level with random spikes so that outliers are found.
  task automatic send_series(int len, int spread);
    logic signed [23:0] base;
    logic signed [23:0] v;
    base = 24'($urandom);
    for (int i = 0; i < len; i++) begin
      v = 24'(base + $signed($urandom_range(0, 2 * spread)) - spread);
      if ($urandom_range(99) < 15) v = 24'($urandom);
      send_sample(v, i == len - 1);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes and the short series case at reset settings.
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(-24'sh800000, 1'b1);
    send_sample(24'sd5, 1'b1);
    for (int i = 0; i < 7; i++) send_sample(i == 3 ? 24'sd1000 : 24'sd10, 1'b0);
    // Zero deviation: centre sample equal to mid range.
    send_sample(24'sd10, 1'b0);
    send_sample(24'sd10, 1'b1);
    drain();
    write_reg(wcof_pkg::REG_REPLACE, 32'd1);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 9; i++) send_sample(i == 4 ? -24'sd5000 : (i % 2 ? 24'sd3 : -24'sd4),
                                            i == 8);
    // Full-width time and all bits of the series marker.
    clock_ticks = 32'hFFFF_FF00;
    send_sample(24'sh0, 1'b1);
    clock_ticks = 0;
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: begin send_idle_pct = 27; recv_idle_pct = 61; end
        1: begin send_idle_pct = 61; recv_idle_pct = 27; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      // Extremes and random settings, written only while the block is idle.
      write_reg(wcof_pkg::REG_WIDTH, phase == 0 ? 32'd31 : (phase == 1 ? 32'd0 : $urandom));
      write_reg(wcof_pkg::REG_K, phase == 0 ? 32'd15 : $urandom);
      write_reg(wcof_pkg::REG_THRESH,
                phase == 1 ? 32'hFFFF : (phase == 2 ? 32'd0 : $urandom));
      write_reg(wcof_pkg::REG_REPLACE, $urandom);
      write_reg(wcof_pkg::REG_BEGIN,
                phase == 3 ? 32'd3000 : (phase == 4 ? 32'hFFFFFFFF : 32'd0));
      write_reg(wcof_pkg::REG_END,
                phase == 3 ? 32'd200 : (phase == 4 ? 32'h0 : 32'hFFFFFFFF));
      write_reg(REG_UNUSED, $urandom);
      cfg_valid <= 1'b0;
      for (int sent = 0; sent < 45;) begin
        int len;
        len = $urandom_range(1, 24);
        send_series(len, $urandom_range(1, 300));
        sent += len;
      end
      drain();
    end

    if (fail_count == 0)
      $display("[window_cluster_outlier_filter] OK");
    else
      $display("[window_cluster_outlier_filter] ERROR");
    $finish;
  end
endmodule
